@@ src/ucb_pkg.sv @@
`timescale 1ns / 1ps
package ucb_pkg;
  localparam int ARMS_DEF       = 10;
  localparam int COUNT_BITS_DEF = 16;

  localparam int Q_W     = 16;  // estimate, Q0.16
  localparam int GAIN_W  = 16;  // gain, Q4.12
  localparam int SCORE_W = 20;  // score, Q4.16
  localparam int LN_W    = 21;  // ln(total), Q.16
  localparam int ROOT_W  = 19;  // sqrt of a 38-bit radicand
  localparam int PROD_W  = GAIN_W + ROOT_W;
  localparam int BONUS_W = PROD_W - 12;

  localparam logic [15:0]        LN2_Q16    = 16'd45426;
  localparam logic [Q_W-1:0]     ONE_Q16    = 16'hFFFF;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd8192;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 20'hFFFFF;
endpackage

@@ src/ucb_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ucb_div #(
  parameter int NW = 21,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    num_r;
  logic [DW:0]      rem_r;
  logic [DW-1:0]    den_r;
  logic [DW:0]      rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r[DW-1:0], num_r[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub : rem_sh;
        num_r <= {num_r[NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;
endmodule

@@ src/ucb_sqrt.sv @@
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one result bit per cycle.
module ucb_sqrt #(
  parameter int RW = 19
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] rad,
  output logic            done,
  output logic [RW-1:0]   root
);
  localparam int CNT_W = $clog2(RW + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [2*RW-1:0]  rad_r;
  logic [RW+1:0]    rem_r;
  logic [RW-1:0]    res_r;
  logic [RW+1:0]    rem_sh, trial;
  logic             ge;

  assign rem_sh = {rem_r[RW-1:0], rad_r[2*RW-1 -: 2]};
  assign trial  = {res_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RW);
        rad_r  <= rad;
        rem_r  <= '0;
        res_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sh - trial : rem_sh;
        res_r <= {res_r[RW-2:0], ge};
        rad_r <= {rad_r[2*RW-3:0], 2'b00};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r;
endmodule

@@ src/ucb_ln.sv @@
`timescale 1ns / 1ps
// Natural log in Q.16: normalize bit by bit, 16 squarings for log2 fraction,
// then scale by ln 2.
module ucb_ln
  import ucb_pkg::*;
#(
  parameter int CW = COUNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [CW-1:0]   x,
  output logic            done,
  output logic [LN_W-1:0] lnv
);
  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_FIX, L_SCALE, L_FIN} ln_state_t;

  ln_state_t        state_r;
  logic             done_r;
  logic [31:0]      m_r;
  logic [4:0]       p_r;
  logic [15:0]      frac_r;
  logic [3:0]       k_r;
  logic [63:0]      prod_r;
  logic [LN_W-1:0]  lnv_r;
  logic [32:0]      t;

  assign t = prod_r[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (start) begin
            m_r    <= 32'(x);
            p_r    <= 5'd31;
            frac_r <= '0;
            k_r    <= '0;
            if (x == '0) begin
              lnv_r  <= '0;
              done_r <= 1'b1;
            end else begin
              state_r <= L_NORM;
            end
          end
        end
        L_NORM: begin
          if (m_r[31]) begin
            state_r <= L_SQ;
          end else begin
            m_r <= {m_r[30:0], 1'b0};
            p_r <= p_r - 1'b1;
          end
        end
        L_SQ: begin
          prod_r  <= m_r * m_r;
          state_r <= L_FIX;
        end
        L_FIX: begin
          frac_r <= {frac_r[14:0], t[32]};
          m_r    <= t[32] ? t[32:1] : t[31:0];
          k_r    <= k_r + 1'b1;
          state_r <= (k_r == 4'd15) ? L_SCALE : L_SQ;
        end
        L_SCALE: begin
          prod_r  <= 64'({p_r, frac_r} * LN2_Q16);
          state_r <= L_FIN;
        end
        L_FIN: begin
          lnv_r   <= prod_r[16 +: LN_W];
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign lnv  = lnv_r;
endmodule

@@ src/ucb1_bandit_arm_selector_unit.sv @@
`timescale 1ns / 1ps
// UCB1 arm selector. One transaction at a time; in_stall is high while busy.
// The estimate update runs a 21-bit serial divide; exploring steps then issue
// directly. Scoring steps add ln plus, per arm, a serial divide, serial root,
// gain multiply and compare. A new transaction is taken only after the output
// handshake of the previous one.
// Reset (synchronous, rst_n low) clears estimates, counts, arm index; gain -> 2.0.
module ucb1_bandit_arm_selector_unit
  import ucb_pkg::*;
#(
  parameter int ARMS       = ARMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_reward,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_next_arm,
  output logic              out_exploring,
  output logic [15:0]       out_total_pulls,
  input  logic              cfg_we,
  input  logic [GAIN_W-1:0] cfg_wdata
);
  localparam int AW = $clog2(ARMS);
  localparam int EW = $clog2(ARMS + 1);
  localparam int CW = COUNT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_UPD_W, S_LN, S_LN_W, S_DIV, S_DIV_W,
    S_SQ, S_SQ_W, S_MUL, S_ADD, S_OUT
  } state_t;

  state_t              state_r;
  logic [Q_W-1:0]      est_r [ARMS];
  logic [CW-1:0]       cnt_r [ARMS];
  logic [CW-1:0]       total_r;
  logic [AW-1:0]       cur_r, idx_r, best_r, chosen_r;
  logic [EW-1:0]       explored_r;
  logic [GAIN_W-1:0]   gain_r;
  logic                reward_r, explore_r, out_valid_r;
  logic [SCORE_W-1:0]  best_score_r;
  logic [LN_W-1:0]     lnv_r;
  logic [ROOT_W-1:0]   root_r;
  logic [PROD_W-1:0]   prod_r;

  // shared unit hookups
  logic                div_start, div_done, sq_start, sq_done, ln_start, ln_done;
  logic [LN_W-1:0]     div_num, div_quo, ln_out;
  logic [CW-1:0]       div_den;
  logic [ROOT_W-1:0]   sq_root;
  logic [Q_W-1:0]      q_cur, diff;
  logic [SCORE_W+3:0]  score_sum;
  logic [SCORE_W-1:0]  score;
  logic [EW-1:0]       explored_inc;

  assign q_cur     = est_r[cur_r];
  assign diff      = reward_r ? (ONE_Q16 - q_cur) : q_cur;
  assign div_start = (state_r == S_UPD) || (state_r == S_DIV);
  assign div_num   = (state_r == S_UPD) ? LN_W'(diff) : lnv_r;
  assign div_den   = (state_r == S_UPD) ? cnt_r[cur_r] : cnt_r[idx_r];
  assign sq_start  = (state_r == S_SQ);
  assign ln_start  = (state_r == S_LN);

  assign score_sum = (SCORE_W + 4)'(est_r[idx_r]) + (SCORE_W + 4)'(prod_r[PROD_W-1:12]);
  assign score     = (score_sum > (SCORE_W + 4)'(SCORE_MAX)) ? SCORE_MAX
                                                             : score_sum[SCORE_W-1:0];
  assign explored_inc = explored_r + 1'b1;

  ucb_div #(.NW(LN_W), .DW(CW)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  ucb_sqrt #(.RW(ROOT_W)) u_sqrt (
    .clk, .rst_n, .start(sq_start), .rad({1'b0, div_quo, 16'b0}),
    .done(sq_done), .root(sq_root)
  );

  ucb_ln #(.CW(CW)) u_ln (
    .clk, .rst_n, .start(ln_start), .x(total_r), .done(ln_done), .lnv(ln_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      explored_r  <= '0;
      total_r     <= '0;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ARMS; i++) begin
        est_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) gain_r <= cfg_wdata;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            reward_r <= in_reward;
            if (cnt_r[cur_r] != '1) cnt_r[cur_r] <= cnt_r[cur_r] + 1'b1;
            if (total_r != '1) total_r <= total_r + 1'b1;
            state_r <= S_UPD;
          end
        end
        S_UPD: state_r <= S_UPD_W;
        S_UPD_W: begin
          if (div_done) begin
            est_r[cur_r] <= reward_r ? q_cur + div_quo[Q_W-1:0]
                                     : q_cur - div_quo[Q_W-1:0];
            if (explored_r != EW'(ARMS)) begin
              explored_r <= explored_inc;
              if (explored_inc != EW'(ARMS)) begin
                chosen_r    <= explored_inc[AW-1:0];
                explore_r   <= 1'b1;
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end else begin
                state_r <= S_LN;
              end
            end else begin
              state_r <= S_LN;
            end
          end
        end
        S_LN: state_r <= S_LN_W;
        S_LN_W: begin
          if (ln_done) begin
            lnv_r   <= ln_out;
            idx_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: state_r <= S_DIV_W;
        S_DIV_W: if (div_done) state_r <= S_SQ;
        S_SQ: state_r <= S_SQ_W;
        S_SQ_W: begin
          if (sq_done) begin
            root_r  <= sq_root;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= gain_r * root_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          // strict compare keeps ties on the lower index
          if (idx_r == '0 || score > best_score_r) begin
            best_r       <= idx_r;
            best_score_r <= score;
          end
          if (idx_r == AW'(ARMS - 1)) begin
            chosen_r    <= (idx_r == '0 || score > best_score_r) ? idx_r : best_r;
            explore_r   <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_DIV;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            cur_r       <= chosen_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic [AW+3:0] arm_ext;
  logic [CW+15:0] total_ext;

  assign arm_ext         = {4'b0, chosen_r};
  assign total_ext       = {16'b0, total_r};
  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_next_arm    = arm_ext[3:0];
  assign out_exploring   = explore_r;
  assign out_total_pulls = (total_ext > (CW + 16)'(16'hFFFF)) ? 16'hFFFF : total_ext[15:0];

  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_explore_unpulled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_exploring) |-> (cnt_r[chosen_r] == '0))
    else $error("exploring arm already pulled");

  a_score_all_pulled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_exploring) |-> (explored_r == EW'(ARMS)))
    else $error("scored while arms unpulled");
endmodule

@@ test/tb_ucb1_bandit_arm_selector_unit.sv @@
`timescale 1ns / 1ps
module tb_ucb1_bandit_arm_selector_unit
  import ucb_pkg::*;
();

  localparam int NARMS = ARMS_DEF;
  localparam int CBITS = COUNT_BITS_DEF;
  localparam logic [63:0] CMAX = (64'd1 << CBITS) - 1;

  typedef struct packed {
    logic [3:0]  next_arm;
    logic        exploring;
    logic [15:0] total_pulls;
  } choice_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_reward = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_next_arm;
  logic out_exploring;
  logic [15:0] out_total_pulls;
  logic cfg_we = 1'b0;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  ucb1_bandit_arm_selector_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_reward(in_reward),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_next_arm(out_next_arm), .out_exploring(out_exploring),
    .out_total_pulls(out_total_pulls),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [15:0] gain_m;
  logic [15:0] est_m [NARMS];
  logic [63:0] cnt_m [NARMS];
  logic [63:0] tot_m;
  int unsigned arm_m;

  logic    reward_q[$];
  choice_t choice_q[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles = 0;

  function automatic logic [63:0] ln_fix(logic [63:0] x);
    int unsigned p;
    logic [127:0] m;
    logic [63:0] frac;
    p = 0;
    frac = 0;
    if (x == 0) return 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    if (p <= 31) m = 128'(x) << (31 - p);
    else m = 128'(x) >> (p - 31);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (128'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (((64'(p) << 16) | frac) * 64'(LN2_Q16)) >> 16;
  endfunction

  function automatic logic [63:0] root_fix(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic choice_t pick_next_arm(logic reward);
    choice_t c;
    int unsigned a, best;
    logic [15:0] t, q, d;
    logic [63:0] lnv, r, s;
    logic [63:0] sc [NARMS];
    bit explore;
    a = arm_m % NARMS;
    t = reward ? ONE_Q16 : 16'd0;
    explore = 0;
    best = 0;
    if (cnt_m[a] < CMAX) cnt_m[a]++;
    if (tot_m < CMAX) tot_m++;
    q = est_m[a];
    if (t >= q) begin
      d = 16'((64'(t - q)) / cnt_m[a]);
      q = q + d;
    end else begin
      d = 16'((64'(q - t)) / cnt_m[a]);
      q = q - d;
    end
    est_m[a] = q;
    for (int i = 0; i < NARMS; i++)
      if (!explore && cnt_m[i] == 0) begin
        best = i;
        explore = 1;
      end
    if (!explore) begin
      lnv = ln_fix(tot_m);
      for (int i = 0; i < NARMS; i++) begin
        r = lnv / cnt_m[i];
        s = 64'(est_m[i]) + ((64'(gain_m) * root_fix(r << 16)) >> 12);
        sc[i] = (s > 64'(SCORE_MAX)) ? 64'(SCORE_MAX) : s;
      end
      for (int i = 1; i < NARMS; i++)
        if (sc[i] > sc[best]) best = i;
    end
    arm_m = best;
    c.next_arm = 4'(best);
    c.exploring = explore;
    c.total_pulls = (tot_m > 64'hFFFF) ? 16'hFFFF : tot_m[15:0];
    return c;
  endfunction

  // acceptance flag sampled at posedge, consumed at negedge
  logic in_stall_prev_acc = 1'b0;
  always @(posedge clk) in_stall_prev_acc <= in_valid && !in_stall;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      choice_q.push_back(pick_next_arm(in_reward));
      void'(reward_q.pop_front());
    end
  end

  // driver: in_valid stays high until the transaction is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_stall_prev_acc) begin
        if (reward_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_reward <= reward_q[0];
        end else begin
          in_valid <= 1'b0;
          in_reward <= 1'($urandom_range(1));
        end
      end
    end
  end

  // receiver; a long hold is counted down here
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    choice_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (choice_q.size() == 0) begin
        $error("unexpected transaction arm=%0d", out_next_arm);
        errors++;
      end else begin
        e = choice_q.pop_front();
        if (out_next_arm !== e.next_arm) begin
          $error("next_arm exp %0d got %0d", e.next_arm, out_next_arm);
          errors++;
        end
        if (out_exploring !== e.exploring) begin
          $error("exploring exp %0d got %0d", e.exploring, out_exploring);
          errors++;
        end
        if (out_total_pulls !== e.total_pulls) begin
          $error("total_pulls exp %0d got %0d", e.total_pulls, out_total_pulls);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (reward_q.size() > 0 || in_valid || choice_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_gain(logic [15:0] g);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we <= 1'b0;
    gain_m = g;
  endtask

  task automatic queue_rewards(int n, int ones_pct);
    for (int i = 0; i < n; i++) reward_q.push_back($urandom_range(99) < ones_pct);
  endtask

  initial begin
    logic [15:0] gains [6];
    gain_m = GAIN_RESET;
    for (int i = 0; i < NARMS; i++) begin
      est_m[i] = 0;
      cnt_m[i] = 0;
    end
    tot_m = 0;
    arm_m = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: exploring sweep with mixed rewards, then a few scoring steps
    for (int i = 0; i < 20; i++) reward_q.push_back(i % 3 == 0);
    drain();
    // hold off the receiver while the sender keeps offering
    hold_cycles = 400;
    queue_rewards(30, 50);
    drain();
    gains = '{16'd0, 16'hFFFF, 16'd4096, 16'd1, 16'd12000, 16'd8192};
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (ph < 6) write_gain(gains[ph]);
      else write_gain(16'($urandom_range(16'hFFFF)));
      queue_rewards(200, (ph * 13) % 100);
      drain();
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("FAILURE");
    $finish;
  end
endmodule
